>>> sv/vsvc_pkg.sv
// Shared types, layout constants and the unpack length function for the
// strip vertex counter. No dependencies.
`timescale 1ns / 1ps

package vsvc_pkg;

    localparam int TOTAL_BITS = 24;
    localparam int OUT_BITS   = 24;
    localparam int SKIP_W     = 11;
    localparam int CNT_W      = 15;

    localparam logic [31:0] W_HEADER = 32'h6C01_8000;
    localparam logic [31:0] W_MASK   = 32'h2000_0000;
    localparam logic [31:0] W_ROW    = 32'h3000_0000;
    localparam logic [31:0] W_KICK   = 32'h1400_0006;
    localparam logic [31:0] UNP_SEL  = 32'hFF00_4000;
    localparam logic [31:0] UNP_POS  = 32'h7900_0000;
    localparam logic [31:0] UNP_TEX  = 32'h7600_4000;
    localparam logic [31:0] UNP_COL  = 32'h6F00_0000;

    localparam logic [TOTAL_BITS-1:0] TOTAL_CAP = {TOTAL_BITS{1'b1}};
    localparam logic [OUT_BITS-1:0]   OUT_MAX   = {OUT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CMD   = 2'd1,
        ST_TRUNC = 2'd2
    } status_t;

    typedef enum logic [10:0] {
        PH_START    = 11'b000_0000_0001,
        PH_COUNT    = 11'b000_0000_0010,
        PH_MASK_POS = 11'b000_0000_0100,
        PH_ROW_POS  = 11'b000_0000_1000,
        PH_UNP_POS  = 11'b000_0001_0000,
        PH_MASK_TEX = 11'b000_0010_0000,
        PH_ROW_TEX  = 11'b000_0100_0000,
        PH_UNP_TEX  = 11'b000_1000_0000,
        PH_UNP_COL  = 11'b001_0000_0000,
        PH_KICK     = 11'b010_0000_0000,
        PH_PAD      = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] vertex_total;
        status_t             status;
    } result_t;

    // Bytes per element component for the vl field.
    function automatic logic [2:0] elem_bytes(input logic [1:0] vl);
        logic [2:0] b;
        begin
            case (vl)
                2'd0:    b = 3'd4;
                2'd1:    b = 3'd2;
                2'd2:    b = 3'd1;
                default: b = 3'd2;
            endcase
            return b;
        end
    endfunction

    // Data words that follow an unpack command: ceil(n * size / 4).
    function automatic logic [SKIP_W-1:0] unpack_words(input logic [31:0] w);
        logic [4:0]  sz;
        logic [2:0]  comps;
        logic [11:0] bytes;
        logic [11:0] rounded;
        begin
            comps = 3'({1'b0, w[27:26]}) + 3'd1;
            if ((w & UNP_COL) == UNP_COL)
                sz = 5'd2;
            else
                sz = 5'(comps) * 5'(elem_bytes(w[25:24]));
            bytes   = 12'(w[23:16]) * 12'(sz);
            rounded = bytes + 12'd3;
            return SKIP_W'(rounded[11:2]);
        end
    endfunction

endpackage

>>> sv/vsvc_walker.sv
// Layout walk state, vertex sum and packet status for the strip vertex
// counter. Depends on vsvc_pkg.
`timescale 1ns / 1ps

module vsvc_walker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [31:0]      word,
    input  logic             last,
    output vsvc_pkg::result_t result
);
    import vsvc_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [SKIP_W-1:0]       skip_reg, skip_next;
    logic                    first_reg, first_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic                    err_reg, err_next;
    logic                    bad;
    logic [CNT_W-1:0]        nv;
    logic [TOTAL_BITS:0]     sum;
    logic [31:0]             total_ext;

    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        first_next = first_reg;
        total_next = total_reg;
        bad        = 1'b0;
        nv         = word[CNT_W-1:0];
        sum        = '0;
        if (skip_reg != '0)
        begin
            skip_next = skip_reg - SKIP_W'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    if (!first_reg)
                        nv = (nv >= CNT_W'(2)) ? nv - CNT_W'(2) : '0;
                    first_next = 1'b0;
                    sum        = {1'b0, total_reg} + (TOTAL_BITS+1)'(nv);
                    total_next = (sum > {1'b0, TOTAL_CAP}) ? TOTAL_CAP
                                                          : sum[TOTAL_BITS-1:0];
                    phase_next = PH_MASK_POS;
                end
                PH_MASK_POS, PH_MASK_TEX:
                begin
                    bad        = (word != W_MASK);
                    skip_next  = SKIP_W'(1);
                    phase_next = (phase_reg == PH_MASK_POS) ? PH_ROW_POS : PH_ROW_TEX;
                end
                PH_ROW_POS, PH_ROW_TEX:
                begin
                    bad        = (word != W_ROW);
                    skip_next  = SKIP_W'(4);
                    phase_next = (phase_reg == PH_ROW_POS) ? PH_UNP_POS : PH_UNP_TEX;
                end
                PH_UNP_POS:
                begin
                    bad        = ((word & UNP_SEL) != UNP_POS);
                    skip_next  = unpack_words(word);
                    phase_next = PH_MASK_TEX;
                end
                PH_UNP_TEX:
                begin
                    bad        = ((word & UNP_SEL) != UNP_TEX);
                    skip_next  = unpack_words(word);
                    phase_next = PH_UNP_COL;
                end
                PH_UNP_COL:
                begin
                    bad        = ((word & UNP_SEL) != UNP_COL);
                    skip_next  = unpack_words(word);
                    phase_next = PH_KICK;
                end
                PH_KICK:
                begin
                    bad        = (word != W_KICK);
                    phase_next = PH_PAD;
                end
                PH_PAD:
                begin
                    // zero padding is consumed; anything else opens a batch
                    if (word != '0)
                    begin
                        bad        = (word != W_HEADER);
                        skip_next  = SKIP_W'(3);
                        phase_next = PH_COUNT;
                    end
                end
                default:
                begin
                    bad        = (word != W_HEADER);
                    skip_next  = SKIP_W'(3);
                    phase_next = PH_COUNT;
                end
            endcase
        end
        err_next = err_reg | bad;
    end

    always_comb
    begin
        total_ext = 32'(total_next);
        result.vertex_total = (total_ext > 32'(OUT_MAX)) ? OUT_MAX
                                                          : total_ext[OUT_BITS-1:0];
        if (err_next)
            result.status = ST_CMD;
        else if (phase_next == PH_PAD && skip_next == '0)
            result.status = ST_OK;
        else
            result.status = ST_TRUNC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            skip_reg  <= '0;
            first_reg <= 1'b1;
            total_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (last)
            begin
                // packet done: back to reset values
                phase_reg <= PH_START;
                skip_reg  <= '0;
                first_reg <= 1'b1;
                total_reg <= '0;
                err_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
                first_reg <= first_next;
                total_reg <= total_next;
                err_reg   <= err_next;
            end
        end
    end

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg && !(advance && last) |=> err_reg)
        else $error("error flag dropped inside a packet");

    a_skip_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last && skip_reg != '0 |=> $stable(phase_reg))
        else $error("phase moved while skipping data words");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last |=> total_reg >= $past(total_reg))
        else $error("vertex sum decreased inside a packet");

endmodule

>>> sv/vif_strip_vertex_counter.sv
// Top level of the strip vertex counter: input register, layout walker and
// result register. Depends on vsvc_pkg and vsvc_walker.
//
//  channel  | dir | tdata                              | tlast
//  ---------+-----+------------------------------------+------------------
//  s_axis   | in  | [31:0] word                        | last word of packet
//  m_axis   | out | [23:0] vertex_total, [25:24] status| unused
//
// One word per cycle is taken while no packet-ending word waits on a stalled
// result; a result passes the input register, then the result register.
// Rate is set by the single walker step between the two registers.
// Reset clears the walk state, the input valid and the result valid.
// A stalled result holds only packet-ending words; other words keep flowing.
`timescale 1ns / 1ps

module vif_strip_vertex_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [23:0] vertex_total, [25:24] status, rest zero
);
    import vsvc_pkg::*;

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    logic        advance;

    // a non-last word never needs the result slot
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vsvc_walker u_walker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (in_word_reg),
        .last    (in_last_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.vertex_total};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(advance && in_last_reg))
        else $error("result overwritten before it was taken");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("stalled input item lost");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:24] == ST_OK || m_tdata[25:24] == ST_CMD ||
                      m_tdata[25:24] == ST_TRUNC))
        else $error("undefined status code");

endmodule
